// ----- rtl/gti_pkg.sv -----
// Package for the grid trilinear interpolator: register indexes, reset values,
// fixed-point widths and default sizes. No dependencies.
`default_nettype none
package gti_pkg;

  localparam int NodesPerAxisDefault = 16;
  localparam int GridTypesDefault    = 4;

  localparam int FracBits = 16;
  localparam int FracW    = FracBits + 1;
  localparam int ValW     = 32;
  localparam int InvW     = 24;
  localparam int CellCntW = 4;

  typedef enum logic [2:0] {
    CFG_OFFSET_X      = 3'd0,
    CFG_OFFSET_Y      = 3'd1,
    CFG_OFFSET_Z      = 3'd2,
    CFG_INV_SPACING   = 3'd3,
    CFG_OUTSIDE_VALUE = 3'd4,
    CFG_CELLS_X       = 3'd5,
    CFG_CELLS_Y       = 3'd6,
    CFG_CELLS_Z       = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  localparam logic [InvW-1:0]     InvSpacingReset = 24'd65536;
  localparam logic [CellCntW-1:0] CellsReset      = 4'd15;

endpackage
`default_nettype wire

// ----- rtl/gti_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module gti_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                   wdata_i,
  input  wire logic                               re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                   rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/gti_lerp.sv -----
// One linear blend step a + floor((b - a) * f / 2^16), signed fraction f.
// Depends on gti_pkg.
`default_nettype none
module gti_lerp import gti_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic signed [W-1:0]     a_i,
  input  wire logic signed [W-1:0]     b_i,
  input  wire logic signed [FracW-1:0] f_i,
  output logic      signed [W+1:0]     y_o
);

  logic signed [W:0]         diff;
  logic signed [W+FracW:0]   prod;
  logic signed [W+FracW:0]   prod_sh;

  always_comb begin
    diff    = {b_i[W-1], b_i} - {a_i[W-1], a_i};
    prod    = diff * f_i;
    prod_sh = prod >>> FracBits;
    y_o     = {{2{a_i[W-1]}}, a_i} + prod_sh[W+1:0];
  end

endmodule
`default_nettype wire

// ----- rtl/grid_trilinear_interpolator_top.sv -----
// Grid trilinear interpolator: eight parity-banked node RAMs, 7-stage pipeline.
// Takes one item per cycle while the output is not stalled.
// Rate is set by the single read port of each bank, one corner per bank per item.
// Stall freezes the whole pipeline; nothing is lost or repeated.
// Reset clears valid bits and loads register defaults; node RAM is not cleared.
`default_nettype none
module grid_trilinear_interpolator_top import gti_pkg::*; #(
  parameter int NODES_PER_AXIS = NodesPerAxisDefault,
  parameter int GRID_TYPES     = GridTypesDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // grid_index, node_x, node_y, node_z, node_value, point_x, point_y, point_z
  input  wire logic [143:0] s_axis_tdata,
  // command
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_value
  output logic [31:0]       m_axis_tdata,
  // was_outside
  output logic              m_axis_tuser
);

  localparam int Half  = (NODES_PER_AXIS + 1) / 2;
  localparam int Depth = GRID_TYPES * Half * Half * Half;
  localparam int AW    = Depth > 1 ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(NODES_PER_AXIS);
  localparam logic [6:0] NodesL = 7'(NODES_PER_AXIS);
  localparam logic [6:0] MaxCell = 7'(NODES_PER_AXIS - 1);
  localparam logic [4:0] GridsL = 5'(GRID_TYPES);

  function automatic logic [AW-1:0] addr_f(input logic [1:0] g, input logic [6:0] x,
                                           input logic [6:0] y, input logic [6:0] z);
    int a;
    a = ((int'(g) * Half + int'(x >> 1)) * Half + int'(y >> 1)) * Half + int'(z >> 1);
    return AW'(a);
  endfunction

  // configuration
  logic signed [31:0] off_q [3];
  logic [InvW-1:0]    inv_q;
  logic [31:0]        outv_q;
  logic [3:0]         cells_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
      inv_q    <= InvSpacingReset;
      outv_q   <= '0;
      cells_q[0] <= CellsReset;
      cells_q[1] <= CellsReset;
      cells_q[2] <= CellsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_X:      off_q[0]   <= cfg_data_i;
        CFG_OFFSET_Y:      off_q[1]   <= cfg_data_i;
        CFG_OFFSET_Z:      off_q[2]   <= cfg_data_i;
        CFG_INV_SPACING:   inv_q      <= cfg_data_i[InvW-1:0];
        CFG_OUTSIDE_VALUE: outv_q     <= cfg_data_i;
        CFG_CELLS_X:       cells_q[0] <= cfg_data_i[3:0];
        CFG_CELLS_Y:       cells_q[1] <= cfg_data_i[3:0];
        CFG_CELLS_Z:       cells_q[2] <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic vo_q;
  assign adv = !vo_q || m_axis_tready;
  assign s_axis_tready = adv;

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // stage 1: offset subtract
  logic               cmd1_q, cmd2_q, cmd3_q, cmd4_q, cmd5_q, cmd6_q, cmdo_q;
  logic [1:0]         g1_q, g2_q, g3_q;
  logic [3:0]         n1_q [3];
  logic [3:0]         n2_q [3];
  logic [3:0]         n3_q [3];
  logic [31:0]        nv1_q, nv2_q, nv3_q;
  logic signed [32:0] diff1_d [3];
  logic signed [32:0] diff1_q [3];

  // stage 2: scale
  logic signed [57:0] prod_full [3];
  logic signed [56:0] prod2_q [3];

  // stage 3: cell split
  logic              in3_d [3];
  logic [CW-1:0]     cell3_d [3];
  logic [CW-1:0]     cell3_q [3];
  logic signed [16:0] frac3_d [3];
  logic signed [16:0] frac3_q [3];
  logic              out3_d, out3_q, wok3_d, wok3_q;

  // stage 4: RAM access
  logic              out4_q, out5_q, out6_q;
  logic signed [16:0] frac4_q [3];
  logic signed [16:0] fy5_q, fz5_q, fz6_q;
  logic [2:0]        par4_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff1_d[a] = {s_axis_tdata[77+32*a], s_axis_tdata[46+32*a +: 32]}
                 - {off_q[a][31], off_q[a]};
      prod_full[a] = diff1_q[a] * $signed({1'b0, inv_q});
    end
  end

  logic [56:0] mag  [3];
  logic [24:0] ipart [3];
  logic [6:0]  lim   [3];
  logic        neg   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      neg[a]   = prod2_q[a][56];
      mag[a]   = neg[a] ? 57'(-prod2_q[a]) : prod2_q[a];
      ipart[a] = mag[a][56:32];
      lim[a]   = ({3'b0, cells_q[a]} < MaxCell) ? {3'b0, cells_q[a]} : MaxCell;
      in3_d[a] = !(neg[a] && ipart[a] != '0) && (ipart[a] < {18'b0, lim[a]});
      cell3_d[a] = ipart[a][CW-1:0];
      frac3_d[a] = neg[a] ? -$signed({1'b0, mag[a][31:16]}) : $signed({1'b0, mag[a][31:16]});
    end
    out3_d = ({3'b0, g2_q} >= GridsL) || !in3_d[0] || !in3_d[1] || !in3_d[2];
    wok3_d = ({3'b0, g2_q} < GridsL) && ({3'b0, n2_q[0]} < NodesL)
           && ({3'b0, n2_q[1]} < NodesL) && ({3'b0, n2_q[2]} < NodesL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= v6_q;
    end
  end

  // RAM banks, bank index {z, y, x} parity
  logic [AW-1:0] raddr [8];
  logic [AW-1:0] waddr;
  logic [2:0]    wbank;
  logic          wen;
  logic [31:0]   rdata [8];
  logic [CW-1:0] qc [8][3];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      for (int a = 0; a < 3; a++) begin
        qc[b][a] = (cell3_q[a][0] == b[a]) ? cell3_q[a] : cell3_q[a] + 1'b1;
      end
      raddr[b] = addr_f(g3_q, 7'(qc[b][0]), 7'(qc[b][1]), 7'(qc[b][2]));
    end
    wbank = {n3_q[2][0], n3_q[1][0], n3_q[0][0]};
    waddr = addr_f(g3_q, {3'b0, n3_q[0]}, {3'b0, n3_q[1]}, {3'b0, n3_q[2]});
    wen   = adv && v3_q && (cmd3_q == CMD_WRITE) && wok3_q;
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    gti_ram #(.Width(32), .Depth(Depth)) u_ram (
      .clk_i   (clk_i),
      .we_i    (wen && (wbank == 3'(b))),
      .waddr_i (waddr),
      .wdata_i (nv3_q),
      .re_i    (adv),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  // blend
  logic signed [31:0] corner [8];
  logic signed [33:0] c1_d [4];
  logic signed [33:0] c1_q [4];
  logic signed [35:0] c2_d [2];
  logic signed [35:0] c2_q [2];
  logic signed [37:0] r_d;
  logic [31:0]        res_d;
  logic [31:0]        res_q;
  logic               wout_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      corner[k] = rdata[3'(k) ^ par4_q];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lx
    gti_lerp #(.W(32)) u_lerp (
      .a_i (corner[2*i]), .b_i (corner[2*i+1]), .f_i (frac4_q[0]), .y_o (c1_d[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_ly
    gti_lerp #(.W(34)) u_lerp (
      .a_i (c1_q[2*i]), .b_i (c1_q[2*i+1]), .f_i (fy5_q), .y_o (c2_d[i])
    );
  end

  gti_lerp #(.W(36)) u_lz (
    .a_i (c2_q[0]), .b_i (c2_q[1]), .f_i (fz6_q), .y_o (r_d)
  );

  always_comb begin
    if (cmd6_q == CMD_WRITE) begin
      res_d = '0;
    end else if (out6_q) begin
      res_d = outv_q;
    end else if (r_d > 38'sd2147483647) begin
      res_d = 32'h7fff_ffff;
    end else if (r_d < -38'sd2147483648) begin
      res_d = 32'h8000_0000;
    end else begin
      res_d = r_d[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q <= s_axis_tuser;
      g1_q   <= s_axis_tdata[1:0];
      n1_q[0] <= s_axis_tdata[5:2];
      n1_q[1] <= s_axis_tdata[9:6];
      n1_q[2] <= s_axis_tdata[13:10];
      nv1_q  <= s_axis_tdata[45:14];
      cmd2_q <= cmd1_q;
      g2_q   <= g1_q;
      n2_q   <= n1_q;
      nv2_q  <= nv1_q;
      cmd3_q <= cmd2_q;
      g3_q   <= g2_q;
      n3_q   <= n2_q;
      nv3_q  <= nv2_q;
      out3_q <= out3_d;
      wok3_q <= wok3_d;
      for (int a = 0; a < 3; a++) begin
        diff1_q[a] <= diff1_d[a];
        prod2_q[a] <= prod_full[a][56:0];
        cell3_q[a] <= cell3_d[a];
        frac3_q[a] <= frac3_d[a];
        par4_q[a]  <= cell3_q[a][0];
      end
      cmd4_q  <= cmd3_q;
      out4_q  <= out3_q;
      frac4_q <= frac3_q;
      cmd5_q  <= cmd4_q;
      out5_q  <= out4_q;
      fy5_q   <= frac4_q[1];
      fz5_q   <= frac4_q[2];
      c1_q    <= c1_d;
      cmd6_q  <= cmd5_q;
      out6_q  <= out5_q;
      fz6_q   <= fz5_q;
      c2_q    <= c2_d;
      cmdo_q  <= cmd6_q;
      res_q   <= res_d;
      wout_q  <= out6_q && (cmd6_q == CMD_QUERY);
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = wout_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && !m_axis_tready |=> vo_q)
    else $error("output item dropped during stall");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && (cmdo_q == CMD_WRITE) |-> (res_q == '0) && !wout_q)
    else $error("write item returned nonzero result");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v4_q) && $stable(par4_q))
    else $error("pipeline moved during stall");

  a_no_write_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wen |-> v3_q && adv)
    else $error("node write without advancing item");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for grid_trilinear_interpolator_top: node writes and trilinear
// queries against an in-bench Q16.16 predictor, with random bursts and output stalls.
// Depends on rtl/gti_pkg.sv and rtl/grid_trilinear_interpolator_top.sv.
module testbench;
  import gti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 7;
  localparam int ItemTarget = 1450;
  localparam longint CycleLimit = 600000;

  typedef struct packed {
    logic [31:0] value;
    logic        outside;
  } interp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;

  grid_trilinear_interpolator_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] node_mem [16384];
  bit node_set [16384];
  longint off_x, off_y, off_z, inv_sp, out_val;
  int cells_x, cells_y, cells_z;

  interp_result_t expected_q[$];
  int items_sent, queries_sent, outside_seen, sat_seen, results_seen, mismatches;
  int burst_left, gap_max;
  int hold_req;
  longint cycles;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("[grid_trilinear_interpolator_top] ERROR");
      $finish;
    end
  end

  // result checker and output stall pattern
  int hold_left, stall_mode, mode_cnt;
  always @(posedge clk_i) begin
    interp_result_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata !== exp_r.value || m_axis_tuser !== exp_r.outside) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, outside exp %b got %b",
                     exp_r.value, m_axis_tdata, exp_r.outside, m_axis_tuser);
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (mode_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_cnt = $urandom_range(16, 96);
    end else mode_cnt--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 9) != 0);
        default: m_axis_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  function automatic longint rand_range(longint lo, longint hi);
    longint r;
    r = {$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF;
    return lo + r % (hi - lo + 1);
  endfunction

  function automatic bit axis_map(logic [31:0] pt, longint off, int cells,
                                  output int cell_idx, output longint frac);
    longint prod, mag, ip;
    int lim;
    bit neg;
    prod = (longint'($signed(pt)) - off) * inv_sp;
    neg = prod < 0;
    mag = (neg ? -prod : prod) >> 16;
    ip = mag >> 16;
    frac = mag & 64'hFFFF;
    lim = cells < 15 ? cells : 15;
    cell_idx = 0;
    if (neg && ip != 0) return 0;
    if (ip >= lim) return 0;
    cell_idx = int'(ip);
    if (neg) frac = -frac;
    return 1;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic longint node_val(int g, int x, int y, int z);
    return longint'($signed(node_mem[{g[1:0], x[3:0], y[3:0], z[3:0]}]));
  endfunction

  task automatic cfg_write(cfg_idx_e idx, longint value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[31:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_OFFSET_X: off_x = longint'($signed(value[31:0]));
      CFG_OFFSET_Y: off_y = longint'($signed(value[31:0]));
      CFG_OFFSET_Z: off_z = longint'($signed(value[31:0]));
      CFG_INV_SPACING: inv_sp = value & 64'hFF_FFFF;
      CFG_OUTSIDE_VALUE: out_val = longint'($signed(value[31:0]));
      CFG_CELLS_X: cells_x = int'(value & 15);
      CFG_CELLS_Y: cells_y = int'(value & 15);
      default: cells_z = int'(value & 15);
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 3) @(posedge clk_i);
  endtask

  // one item on the input stream; prediction made when it is accepted
  task automatic send_item(cmd_e cmd, logic [1:0] g, logic [3:0] nx, logic [3:0] ny,
                           logic [3:0] nz, logic [31:0] nv, logic [31:0] px,
                           logic [31:0] py, logic [31:0] pz);
    interp_result_t r;
    int cx, cy, cz;
    longint fx, fy, fz, c0, c1, v;
    bit in_grid;
    if (gap_max > 0 && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b0, pz, py, px, nv, nz, ny, nx, g};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    r = '0;
    if (cmd == CMD_WRITE) begin
      node_mem[{g, nx, ny, nz}] = nv;
      node_set[{g, nx, ny, nz}] = 1'b1;
    end else begin
      queries_sent++;
      in_grid = axis_map(px, off_x, cells_x, cx, fx);
      if (in_grid) in_grid = axis_map(py, off_y, cells_y, cy, fy);
      if (in_grid) in_grid = axis_map(pz, off_z, cells_z, cz, fz);
      if (!in_grid) begin
        r.value = out_val[31:0];
        r.outside = 1'b1;
        outside_seen++;
      end else begin
        c0 = blend(blend(node_val(g, cx, cy, cz), node_val(g, cx + 1, cy, cz), fx),
                   blend(node_val(g, cx, cy + 1, cz), node_val(g, cx + 1, cy + 1, cz), fx),
                   fy);
        c1 = blend(blend(node_val(g, cx, cy, cz + 1), node_val(g, cx + 1, cy, cz + 1), fx),
                   blend(node_val(g, cx, cy + 1, cz + 1),
                         node_val(g, cx + 1, cy + 1, cz + 1), fx), fy);
        v = blend(c0, c1, fz);
        if (v > 64'sd2147483647) begin v = 64'sd2147483647; sat_seen++; end
        if (v < -64'sd2147483648) begin v = -64'sd2147483648; sat_seen++; end
        r.value = v[31:0];
      end
    end
    expected_q = {expected_q, r};
  endtask

  task automatic write_node(int g, int x, int y, int z, logic [31:0] v);
    send_item(CMD_WRITE, g[1:0], x[3:0], y[3:0], z[3:0], v, $urandom, $urandom, $urandom);
  endtask

  // fills any unwritten corner of the cell the point lands in, then queries
  task automatic query(logic [1:0] g, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int cx, cy, cz;
    longint f;
    logic [13:0] a;
    if (axis_map(px, off_x, cells_x, cx, f) && axis_map(py, off_y, cells_y, cy, f) &&
        axis_map(pz, off_z, cells_z, cz, f)) begin
      for (int i = 0; i < 8; i++) begin
        a = {g, 4'(cx + i[0]), 4'(cy + i[1]), 4'(cz + i[2])};
        if (!node_set[a])
          write_node(g, cx + i[0], cy + i[1], cz + i[2],
                     $urandom_range(0, 3) == 0 ? $urandom : 32'($signed(rand_range(-(1 << 24), 1 << 24))));
      end
    end
    send_item(CMD_QUERY, g, $urandom, $urandom, $urandom, $urandom, px, py, pz);
  endtask

  function automatic logic [31:0] point_near(longint off, int cells);
    longint span;
    span = inv_sp == 0 ? (1 << 20) : ((longint'(cells) + 1) << 32) / inv_sp;
    return 32'(off + rand_range(-(span / 8) - 1, span));
  endfunction

  task automatic random_query(bit noise);
    if (noise)
      query($urandom, $urandom, $urandom, $urandom);
    else
      query($urandom, point_near(off_x, cells_x), point_near(off_y, cells_y),
            point_near(off_z, cells_z));
  endtask

  task automatic random_config();
    longint inv_choice [6] = '{65536, 32768, 131072, 16384, 24'hFF_FFFF, 1};
    cfg_write(CFG_INV_SPACING, $urandom_range(0, 5) == 0 ? $urandom_range(1, 24'hFF_FFFF)
                                                          : inv_choice[$urandom_range(0, 5)]);
    cfg_write(CFG_OFFSET_X, $urandom_range(0, 7) == 0 ? $urandom : rand_range(-(1 << 22), 1 << 22));
    cfg_write(CFG_OFFSET_Y, $urandom_range(0, 7) == 0 ? $urandom : rand_range(-(1 << 22), 1 << 22));
    cfg_write(CFG_OFFSET_Z, $urandom_range(0, 7) == 0 ? $urandom : rand_range(-(1 << 22), 1 << 22));
    cfg_write(CFG_OUTSIDE_VALUE, $urandom);
    cfg_write(CFG_CELLS_X, $urandom_range(1, 15));
    cfg_write(CFG_CELLS_Y, $urandom_range(1, 15));
    cfg_write(CFG_CELLS_Z, $urandom_range(1, 15));
  endtask

  task automatic test_reset_defaults();
    for (int g = 0; g < 4; g++)
      query(g[1:0], $urandom_range(0, 32'h000E_FFFF), $urandom_range(0, 32'h000E_FFFF),
            $urandom_range(0, 32'h000E_FFFF));
    wait_idle();
  endtask

  task automatic test_corner_cases();
    cfg_write(CFG_OUTSIDE_VALUE, 32'h8000_0000);
    write_node(3, 15, 15, 15, 32'h7FFF_FFFF);
    write_node(3, 0, 0, 0, 32'h8000_0000);
    write_node(3, 1, 0, 0, 32'h7FFF_FFFF);
    query(3, 32'h0000_FFFF, 0, 0);                // largest fraction
    query(3, 32'hFFFF_8000, 0, 0);                // just below zero, extrapolates
    query(3, 32'h000F_8000, 32'h000E_8000, 32'h000E_8000); // x past the top cell, y and z in it
    query(3, 32'h000F_0000, 0, 0);                // first index past the grid
    query(3, 32'hFFFF_0000, 0, 0);                // minus one cell
    query(2, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    query(1, 0, 0, 32'h000F_0000);                // z bounded by cells_z
    wait_idle();
    cfg_write(CFG_CELLS_Z, 4);
    query(1, 0, 0, 32'h0004_0000);
    query(1, 0, 0, 32'h0003_C000);
    wait_idle();
    cfg_write(CFG_CELLS_Y, 0);                    // empty axis
    query(1, 0, 0, 0);
    wait_idle();
    cfg_write(CFG_INV_SPACING, 0);                // every point maps to node 0
    wait_idle();
    cfg_write(CFG_CELLS_Y, 15);
    query(3, $urandom, $urandom, $urandom);
    query(3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();
    cfg_write(CFG_INV_SPACING, 24'hFF_FFFF);
    cfg_write(CFG_OFFSET_X, 32'h7FFF_FFFF);
    query(0, 32'h7FFF_FFFF, 0, 0);
    query(0, 32'h8000_0000, 0, 0);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int phase;
    phase = 0;
    while (items_sent < ItemTarget) begin
      wait_idle();
      random_config();
      gap_max = (phase % 3 == 2) ? 0 : $urandom_range(1, 8);
      repeat (60) begin
        if (items_sent < ItemTarget) begin
          if ($urandom_range(0, 9) == 0)
            write_node($urandom, $urandom, $urandom, $urandom, $urandom);
          else random_query($urandom_range(0, 9) == 0);
        end
      end
      phase++;
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    hold_req = 400;
    repeat (2) @(posedge clk_i);
    repeat (60) random_query(1'b0);
    wait_idle();
    gap_max = 4;
  endtask

  initial begin
    cycles = 0;
    hold_req = 0;
    gap_max = 3;
    burst_left = 0;
    for (int i = 0; i < 16384; i++) begin
      node_mem[i] = '0;
      node_set[i] = 1'b0;
    end
    off_x = 0; off_y = 0; off_z = 0;
    inv_sp = 65536;
    out_val = 0;
    cells_x = 15; cells_y = 15; cells_z = 15;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_corner_cases();
    test_backpressure();
    test_random_phases();
    repeat (Latency * 4) @(posedge clk_i);
    $display("%0d items (%0d queries), %0d outside, %0d saturated, %0d results checked",
             items_sent, queries_sent, outside_seen, sat_seen, results_seen);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("[grid_trilinear_interpolator_top] OK");
    else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("[grid_trilinear_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gti_pkg.sv
rtl/gti_ram.sv
rtl/gti_lerp.sv
rtl/grid_trilinear_interpolator_top.sv
dv/testbench.sv
